FILE: rtl/core/ste_pkg.sv
// Shared definitions for the stereo treble exciter: widths, fixed-point
// constants, memory slot map, sequencer codes and the MAC control struct.
// No dependencies.
package ste_pkg;

    // Sample format and channel configuration.
    localparam int SW      = 24;
    localparam int FRAC_W  = SW - 1;
    localparam int LANES   = 2;
    localparam int CH_CNT  = 2;
    localparam int PROC_CH = (CH_CNT < LANES) ? CH_CNT : LANES;
    localparam int CH_W    = $clog2(LANES);
    localparam int DATA_W  = ((2 * SW + 7) / 8) * 8;

    // Configuration port.
    localparam int COEF_W     = 25;
    localparam int STR_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COEF_W;

    localparam logic [CFG_IDX_W-1:0] CFG_PRE_B0   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PRE_A1   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_PRE_A2   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_POST_B0  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_POST_A1  = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_POST_A2  = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] CFG_STRENGTH = CFG_IDX_W'(6);

    // Datapath widths.
    localparam int INT_W = 32;
    localparam int D_W   = INT_W + 2;
    localparam int A_W   = D_W;
    localparam int B_W   = (SW + 2 > COEF_W) ? SW + 2 : COEF_W;
    localparam int P_W   = A_W + B_W;
    localparam int ACC_W = P_W + 2;

    // Rescaling shifts and the DC tracking rate.
    localparam int COEF_SHIFT = 22;
    localparam int STR_SHIFT  = 14;
    localparam int DC_SHIFT   = 24;
    localparam int DC_RATE    = 16777;

    // State memory: one row of slots per channel.
    localparam int SLOT_W    = 4;
    localparam int ADDR_W    = CH_W + SLOT_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;

    localparam logic [SLOT_W-1:0] SL_X1   = SLOT_W'(0);
    localparam logic [SLOT_W-1:0] SL_X2   = SLOT_W'(1);
    localparam logic [SLOT_W-1:0] SL_Y1   = SLOT_W'(2);
    localparam logic [SLOT_W-1:0] SL_Y2   = SLOT_W'(3);
    localparam logic [SLOT_W-1:0] SL_POST = SLOT_W'(4);
    localparam logic [SLOT_W-1:0] SL_DC   = SLOT_W'(8);

    // Per-channel sequencer steps.
    localparam int STEP_W = 5;

    localparam logic [STEP_W-1:0] ST_PRE_B0X   = STEP_W'(0);
    localparam logic [STEP_W-1:0] ST_PRE_X1    = STEP_W'(1);
    localparam logic [STEP_W-1:0] ST_PRE_X2    = STEP_W'(2);
    localparam logic [STEP_W-1:0] ST_PRE_Y1    = STEP_W'(3);
    localparam logic [STEP_W-1:0] ST_PRE_Y2    = STEP_W'(4);
    localparam logic [STEP_W-1:0] ST_PRE_LAST  = STEP_W'(5);
    localparam logic [STEP_W-1:0] ST_PRE_OUT   = STEP_W'(6);
    localparam logic [STEP_W-1:0] ST_DC_DIFF   = STEP_W'(7);
    localparam logic [STEP_W-1:0] ST_DC_MUL    = STEP_W'(8);
    localparam logic [STEP_W-1:0] ST_SHAPE_MUL = STEP_W'(9);
    localparam logic [STEP_W-1:0] ST_DC_WR     = STEP_W'(10);
    localparam logic [STEP_W-1:0] ST_SHAPE_OUT = STEP_W'(11);
    localparam logic [STEP_W-1:0] ST_POST_B0X  = STEP_W'(12);
    localparam logic [STEP_W-1:0] ST_POST_X1   = STEP_W'(13);
    localparam logic [STEP_W-1:0] ST_POST_X2   = STEP_W'(14);
    localparam logic [STEP_W-1:0] ST_POST_Y1   = STEP_W'(15);
    localparam logic [STEP_W-1:0] ST_POST_Y2   = STEP_W'(16);
    localparam logic [STEP_W-1:0] ST_POST_LAST = STEP_W'(17);
    localparam logic [STEP_W-1:0] ST_POST_OUT  = STEP_W'(18);
    localparam logic [STEP_W-1:0] ST_MIX_MUL   = STEP_W'(19);
    localparam logic [STEP_W-1:0] ST_MIX_ACC   = STEP_W'(20);
    localparam logic [STEP_W-1:0] ST_MIX_OUT   = STEP_W'(21);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB,
        ACC_SUB2
    } t_acc_op;

    typedef struct packed {
        logic    mul_en;
        t_acc_op op;
    } t_mac_ctl;

endpackage

FILE: rtl/core/stereo_treble_exciter_unit.sv
// Stereo treble exciter: per-channel highpass, rectify, DC removal, soft shaper,
// second highpass and mix. Top level with sequencer and state memory.
// Depends on ste_pkg and ste_mac.
//
// One item is in flight: a new item is taken only in IDLE, once the previous
// result has moved to the output register. Processing is serialised by the
// single shared multiplier and the single-write-port state memory, which each
// channel walks in turn.
// Reset (synchronous, active low) clears the coefficients and strength, the
// control state and the per-entry valid bits of the state memory; unwritten
// history entries read as zero, so no clearing pass is needed after reset.
module stereo_treble_exciter_unit
    import ste_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // Input items.
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // tdata: left_sample [SW-1:0], right_sample [2*SW-1:SW], zero padding above.
    input  logic [DATA_W-1:0]     i_s_tdata,
    input  logic                  i_s_tlast,     // block_end

    // Result items.
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // tdata: left_out [SW-1:0], right_out [2*SW-1:SW], zero padding above.
    output logic [DATA_W-1:0]     o_m_tdata,
    output logic                  o_m_tlast,     // block_end_out

    // Configuration writes.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic signed [INT_W-1:0] I32_MAX = {1'b0, {(INT_W - 1){1'b1}}};
    localparam logic signed [INT_W-1:0] I32_MIN = {1'b1, {(INT_W - 1){1'b0}}};
    localparam logic signed [SW-1:0]    SMP_MAX = {1'b0, {(SW - 1){1'b1}}};
    localparam logic signed [SW-1:0]    SMP_MIN = {1'b1, {(SW - 1){1'b0}}};
    localparam logic signed [D_W-1:0]   D_LIM   = D_W'(1) << SW;
    localparam logic [CH_W-1:0]         LAST_CH = CH_W'(PROC_CH - 1);

    // Round to nearest with ties toward plus infinity, then shift right.
    function automatic logic signed [ACC_W-1:0] rnd_shr(
        input logic signed [ACC_W-1:0] v,
        input int                      s
    );
        logic signed [ACC_W-1:0] half;
        logic signed [ACC_W-1:0] t;
        half = ACC_W'(1) << (s - 1);
        t    = v + half;
        return t >>> s;
    endfunction

    function automatic logic signed [INT_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [INT_W-1:0] r;
        if (v > ACC_W'(I32_MAX)) begin
            r = I32_MAX;
        end else if (v < ACC_W'(I32_MIN)) begin
            r = I32_MIN;
        end else begin
            r = v[INT_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [SW-1:0] sat_smp(input logic signed [ACC_W-1:0] v);
        logic signed [SW-1:0] r;
        if (v > ACC_W'(SMP_MAX)) begin
            r = SMP_MAX;
        end else if (v < ACC_W'(SMP_MIN)) begin
            r = SMP_MIN;
        end else begin
            r = v[SW-1:0];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers. The user must write only while the block is idle;
    // the block does not enforce it. An index past the register list is ignored.
    // ------------------------------------------------------------------
    logic signed [COEF_W-1:0] r_pre_b0, r_pre_a1, r_pre_a2;
    logic signed [COEF_W-1:0] r_post_b0, r_post_a1, r_post_a2;
    logic [STR_W-1:0]         r_strength;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_b0   <= '0;
            r_pre_a1   <= '0;
            r_pre_a2   <= '0;
            r_post_b0  <= '0;
            r_post_a1  <= '0;
            r_post_a2  <= '0;
            r_strength <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PRE_B0:   r_pre_b0   <= i_cfg_data;
                CFG_PRE_A1:   r_pre_a1   <= i_cfg_data;
                CFG_PRE_A2:   r_pre_a2   <= i_cfg_data;
                CFG_POST_B0:  r_post_b0  <= i_cfg_data;
                CFG_POST_A1:  r_post_a1  <= i_cfg_data;
                CFG_POST_A2:  r_post_a2  <= i_cfg_data;
                CFG_STRENGTH: r_strength <= i_cfg_data[STR_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer. An item is taken in IDLE, each processed channel runs the
    // fixed 22-step schedule in RUN, and DONE hands the result to the output
    // register as soon as that register is free or being emptied.
    // ------------------------------------------------------------------
    t_state             r_state, n_state;
    logic [STEP_W-1:0]  r_step;
    logic [CH_W-1:0]    r_ch;
    logic               s_ready;
    logic               out_load;
    logic               ch_done;

    assign ch_done = (r_step == ST_MIX_OUT);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (ch_done && (r_ch == LAST_CH)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!o_m_tvalid || i_m_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        s_ready  = (r_state == S_IDLE);
        out_load = (r_state == S_DONE) && (!o_m_tvalid || i_m_tready);
    end

    assign o_s_tready = s_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= ST_PRE_B0X;
            r_ch    <= '0;
        end else begin
            r_state <= n_state;
            if (s_ready && i_s_tvalid) begin
                r_step <= ST_PRE_B0X;
                r_ch   <= '0;
            end else if (r_state == S_RUN) begin
                if (ch_done) begin
                    r_step <= ST_PRE_B0X;
                    r_ch   <= r_ch + CH_W'(1);
                end else begin
                    r_step <= r_step + STEP_W'(1);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Captured item. The results start as the input samples so that a lane
    // without a processed channel passes through unchanged.
    // ------------------------------------------------------------------
    logic signed [SW-1:0] r_x   [LANES];
    logic signed [SW-1:0] r_res [LANES];
    logic                 r_last;

    // ------------------------------------------------------------------
    // State memory: filter histories and DC level, one row per channel.
    // Read data is registered; the schedule reads each entry before it is
    // rewritten in the same item, so reads and writes never collide.
    // ------------------------------------------------------------------
    logic [INT_W-1:0]     r_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] r_vld;
    logic [INT_W-1:0]     r_rd;
    logic                 r_rd_vld;

    logic                 rd_en, wr_en;
    logic [SLOT_W-1:0]    rd_slot, wr_slot;
    logic [ADDR_W-1:0]    rd_addr, wr_addr;
    logic [INT_W-1:0]     wr_data;
    logic signed [INT_W-1:0] rd_val;

    assign rd_addr = {r_ch, rd_slot};
    assign wr_addr = {r_ch, wr_slot};
    assign rd_val  = r_rd_vld ? $signed(r_rd) : '0;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                r_rd_vld <= r_vld[rd_addr];
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers and the shared multiply-accumulate unit.
    // ------------------------------------------------------------------
    logic signed [INT_W-1:0] r_hold;   // history value carried to its next slot
    logic signed [INT_W-1:0] r_y;      // biquad output (pre, later post)
    logic signed [INT_W-1:0] r_dc;     // DC level read for this channel
    logic signed [INT_W-1:0] r_s;      // shaped signal, input of second highpass
    logic signed [D_W-1:0]   r_d;      // rectified value minus DC level
    logic signed [A_W-1:0]   r_lm;     // 2.0 minus magnitude of the clipped value
    logic signed [B_W-1:0]   r_dq;     // value clipped to plus or minus 2.0

    t_mac_ctl                mac_ctl;
    logic signed [A_W-1:0]   mul_a;
    logic signed [B_W-1:0]   mul_b;
    logic signed [ACC_W-1:0] acc;

    ste_mac u_mac (
        .i_clk (i_clk),
        .i_ctl (mac_ctl),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_acc (acc)
    );

    // Values derived from the accumulator and the datapath registers.
    logic                    is_post;
    logic [SLOT_W-1:0]       sb;
    logic signed [SW-1:0]    cur_x;
    logic signed [A_W-1:0]   bq_x;
    logic signed [B_W-1:0]   b0c, a1c, a2c;
    logic signed [INT_W-1:0] bq_out;
    logic signed [INT_W-1:0] dc_new;
    logic signed [INT_W-1:0] s_next;
    logic signed [SW-1:0]    mix;
    logic signed [D_W-1:0]   y_ext, y_abs, d_next;
    logic signed [D_W-1:0]   d_clip, d_mag;

    always_comb begin
        is_post = (r_step >= ST_POST_B0X);
        sb      = is_post ? SL_POST : SL_X1;
        cur_x   = r_x[r_ch];
        bq_x    = is_post ? A_W'(r_s) : A_W'(cur_x);
        b0c     = is_post ? B_W'(r_post_b0) : B_W'(r_pre_b0);
        a1c     = is_post ? B_W'(r_post_a1) : B_W'(r_pre_a1);
        a2c     = is_post ? B_W'(r_post_a2) : B_W'(r_pre_a2);

        bq_out  = sat32(rnd_shr(acc, COEF_SHIFT));
        dc_new  = sat32(ACC_W'(r_dc) + rnd_shr(acc, DC_SHIFT));
        s_next  = sat32(rnd_shr(acc, FRAC_W));
        mix     = sat_smp(ACC_W'(cur_x) + rnd_shr(acc, STR_SHIFT));

        // Rectify the first highpass output and remove the tracked DC level.
        y_ext   = D_W'(r_y);
        y_abs   = (r_y < 0) ? -y_ext : y_ext;
        d_next  = y_abs - D_W'(r_dc);

        // Clip to plus or minus 2.0 ahead of the h*(2-|h|) shaper.
        if (r_d > D_LIM) begin
            d_clip = D_LIM;
        end else if (r_d < -D_LIM) begin
            d_clip = -D_LIM;
        end else begin
            d_clip = r_d;
        end
        d_mag = (d_clip < 0) ? -d_clip : d_clip;
    end

    // Step decode: memory accesses, multiplier operands, accumulator action
    // and register loads for the current step of the current channel. Each
    // product is formed in the step after its read and accumulated in the next step.
    logic ld_hold, ld_y, ld_dc, ld_d, ld_clip, ld_s, ld_res;

    always_comb begin
        rd_en          = 1'b0;
        rd_slot        = SL_X1;
        wr_en          = 1'b0;
        wr_slot        = SL_X1;
        wr_data        = '0;
        mul_a          = '0;
        mul_b          = '0;
        mac_ctl.mul_en = 1'b0;
        mac_ctl.op     = ACC_NONE;
        ld_hold        = 1'b0;
        ld_y           = 1'b0;
        ld_dc          = 1'b0;
        ld_d           = 1'b0;
        ld_clip        = 1'b0;
        ld_s           = 1'b0;
        ld_res         = 1'b0;
        if (r_state == S_RUN) begin
            unique case (r_step) inside
                ST_PRE_B0X, ST_POST_B0X: begin
                    rd_en          = 1'b1;
                    rd_slot        = sb + SL_X1;
                    mul_a          = bq_x;
                    mul_b          = b0c;
                    mac_ctl.mul_en = 1'b1;
                end
                ST_PRE_X1, ST_POST_X1: begin
                    mac_ctl.op     = ACC_LOAD;
                    mul_a          = A_W'(rd_val);
                    mul_b          = b0c;
                    mac_ctl.mul_en = 1'b1;
                    rd_en          = 1'b1;
                    rd_slot        = sb + SL_X2;
                    wr_en          = 1'b1;
                    wr_slot        = sb + SL_X1;
                    wr_data        = bq_x[INT_W-1:0];
                    ld_hold        = 1'b1;
                end
                ST_PRE_X2, ST_POST_X2: begin
                    mac_ctl.op     = ACC_SUB2;
                    mul_a          = A_W'(rd_val);
                    mul_b          = b0c;
                    mac_ctl.mul_en = 1'b1;
                    rd_en          = 1'b1;
                    rd_slot        = sb + SL_Y1;
                    wr_en          = 1'b1;
                    wr_slot        = sb + SL_X2;
                    wr_data        = r_hold;
                end
                ST_PRE_Y1, ST_POST_Y1: begin
                    mac_ctl.op     = ACC_ADD;
                    mul_a          = A_W'(rd_val);
                    mul_b          = a1c;
                    mac_ctl.mul_en = 1'b1;
                    rd_en          = 1'b1;
                    rd_slot        = sb + SL_Y2;
                    ld_hold        = 1'b1;
                end
                ST_PRE_Y2, ST_POST_Y2: begin
                    mac_ctl.op     = ACC_SUB;
                    mul_a          = A_W'(rd_val);
                    mul_b          = a2c;
                    mac_ctl.mul_en = 1'b1;
                    wr_en          = 1'b1;
                    wr_slot        = sb + SL_Y2;
                    wr_data        = r_hold;
                end
                ST_PRE_LAST, ST_POST_LAST: begin
                    mac_ctl.op = ACC_SUB;
                    rd_en      = !is_post;
                    rd_slot    = SL_DC;
                end
                ST_PRE_OUT, ST_POST_OUT: begin
                    wr_en   = 1'b1;
                    wr_slot = sb + SL_Y1;
                    wr_data = bq_out;
                    ld_y    = 1'b1;
                    ld_dc   = !is_post;
                end
                ST_DC_DIFF: begin
                    ld_d = 1'b1;
                end
                ST_DC_MUL: begin
                    mul_a          = r_d;
                    mul_b          = B_W'(DC_RATE);
                    mac_ctl.mul_en = 1'b1;
                    ld_clip        = 1'b1;
                end
                ST_SHAPE_MUL: begin
                    mac_ctl.op     = ACC_LOAD;
                    mul_a          = r_lm;
                    mul_b          = r_dq;
                    mac_ctl.mul_en = 1'b1;
                end
                ST_DC_WR: begin
                    mac_ctl.op = ACC_LOAD;
                    wr_en      = 1'b1;
                    wr_slot    = SL_DC;
                    wr_data    = dc_new;
                end
                ST_SHAPE_OUT: begin
                    ld_s = 1'b1;
                end
                ST_MIX_MUL: begin
                    mul_a          = A_W'(r_y);
                    mul_b          = B_W'({1'b0, r_strength});
                    mac_ctl.mul_en = 1'b1;
                end
                ST_MIX_ACC: begin
                    mac_ctl.op = ACC_LOAD;
                end
                ST_MIX_OUT: begin
                    ld_res = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_ready && i_s_tvalid) begin
            r_x[0]   <= i_s_tdata[SW-1:0];
            r_x[1]   <= i_s_tdata[2*SW-1:SW];
            r_res[0] <= i_s_tdata[SW-1:0];
            r_res[1] <= i_s_tdata[2*SW-1:SW];
            r_last   <= i_s_tlast;
        end else if (ld_res) begin
            r_res[r_ch] <= mix;
        end
        if (ld_hold) begin
            r_hold <= rd_val;
        end
        if (ld_y) begin
            r_y <= bq_out;
        end
        if (ld_dc) begin
            r_dc <= rd_val;
        end
        if (ld_d) begin
            r_d <= d_next;
        end
        if (ld_clip) begin
            r_lm <= D_LIM - d_mag;
            r_dq <= B_W'(d_clip);
        end
        if (ld_s) begin
            r_s <= s_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register. It holds a finished item while the next input item
    // is already being taken and processed.
    // ------------------------------------------------------------------
    logic              r_m_valid;
    logic [DATA_W-1:0] r_m_data;
    logic              r_m_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_data <= DATA_W'({r_res[1], r_res[0]});
            r_m_last <= r_last;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tlast  = r_m_last;

endmodule

FILE: rtl/core/ste_mac.sv
// Shared multiply-accumulate unit of the stereo treble exciter.
// One product per cycle, when enabled, is registered and feeds the accumulator in the next cycle.
// Depends on ste_pkg.
module ste_mac
    import ste_pkg::*;
(
    input  logic                    i_clk,
    input  t_mac_ctl                i_ctl,
    input  logic signed [A_W-1:0]   i_a,
    input  logic signed [B_W-1:0]   i_b,
    output logic signed [ACC_W-1:0] o_acc
);

    logic signed [P_W-1:0]   r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] n_acc;
    logic signed [ACC_W-1:0] prod_ext;

    assign prod_ext = ACC_W'(r_prod);

    always_comb begin
        case (i_ctl.op)
            ACC_LOAD: n_acc = prod_ext;
            ACC_ADD:  n_acc = r_acc + prod_ext;
            ACC_SUB:  n_acc = r_acc - prod_ext;
            ACC_SUB2: n_acc = r_acc - (prod_ext <<< 1);
            default:  n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= i_a * i_b;
        end
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for stereo_treble_exciter_unit: a short directed table, then random
// register settings and sample pairs, checked by a bit-true predictor or typed-in values.
// Depends on ste_pkg and the RTL of the unit.
module testbench;
    import ste_pkg::*;

    localparam int     HALF_PERIOD   = 6;
    localparam int     RESET_CYCLES  = 12;
    localparam int     PHASES        = 9;
    localparam int     PHASE_ITEMS   = 148;
    localparam int     SETTLE_CYCLES = 64;
    localparam int     SHOWN_ERRORS  = 10;
    localparam longint TIMEOUT_NS    = 8_000_000;

    // Index 7 decodes to no register; writes to it must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(7);

    localparam logic signed [SW-1:0]     SAMPLE_MAX = {1'b0, {(SW - 1){1'b1}}};
    localparam logic signed [SW-1:0]     SAMPLE_MIN = {1'b1, {(SW - 1){1'b0}}};
    localparam logic [CFG_DATA_W-1:0]    COEF_MAX   = {1'b0, {(COEF_W - 1){1'b1}}};
    localparam logic [CFG_DATA_W-1:0]    COEF_MIN   = {1'b1, {(COEF_W - 1){1'b0}}};
    localparam logic [STR_W-1:0]         STR_MAX    = '1;

    localparam longint I32_MAX = (longint'(1) <<< 31) - 1;
    localparam longint I32_MIN = -I32_MAX - 1;
    localparam longint OUT_MAX = (longint'(1) <<< (SW - 1)) - 1;
    localparam longint OUT_MIN = -OUT_MAX - 1;

    // One sample pair as it leaves the unit.
    typedef struct packed {
        logic signed [SW-1:0] left;
        logic signed [SW-1:0] right;
        logic                 last;
    } pair_t;

    // Filter memory of one biquad for one channel.
    typedef struct packed {
        int x1;
        int x2;
        int y1;
        int y2;
    } hist_t;

    typedef enum logic {
        ROW_REG,
        ROW_PAIR
    } row_kind_e;

    // One row of the directed table: either a register write or a sample pair. Rows with
    // known set carry their expected output, typed in; the others are predicted.
    typedef struct packed {
        row_kind_e               kind;
        logic [CFG_IDX_W-1:0]    reg_idx;
        logic [CFG_DATA_W-1:0]   reg_val;
        logic signed [SW-1:0]    left;
        logic signed [SW-1:0]    right;
        logic                    last;
        logic                    known;
        logic signed [SW-1:0]    exp_left;
        logic signed [SW-1:0]    exp_right;
    } plan_row_t;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [DATA_W-1:0]     i_s_tdata   = '0;
    logic                  i_s_tlast   = 1'b0;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [DATA_W-1:0]     o_m_tdata;
    logic                  o_m_tlast;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    stereo_treble_exciter_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #(HALF_PERIOD) i_clk = 1'b1;
        #(HALF_PERIOD) i_clk = 1'b0;
    end

    // Safety net: the slowest legal run is far shorter than this.
    initial begin
        #(TIMEOUT_NS);
        $display("testbench: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------------------------
    // Exciter predictor. It keeps its own copy of the registers and of the filter and DC
    // state, and is advanced exactly once per accepted sample pair.
    // ------------------------------------------------------------------------------------
    logic signed [COEF_W-1:0] pre_b0, pre_a1, pre_a2;
    logic signed [COEF_W-1:0] post_b0, post_a1, post_a2;
    logic [STR_W-1:0]         strength;
    hist_t                    pre_hist  [CH_CNT];
    hist_t                    post_hist [CH_CNT];
    int                       dc_level  [CH_CNT];

    initial begin
        pre_b0 = '0; pre_a1 = '0; pre_a2 = '0;
        post_b0 = '0; post_a1 = '0; post_a2 = '0;
        strength = '0;
        for (int c = 0; c < CH_CNT; c++) begin
            pre_hist[c]  = '0;
            post_hist[c] = '0;
            dc_level[c]  = 0;
        end
    end

    // Round to nearest with ties toward plus infinity, then drop s fraction bits.
    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int sat32(longint v);
        return int'(clamp(v, I32_MIN, I32_MAX));
    endfunction

    // Direct-form-I highpass with b1 = -2*b0 and b2 = b0. The output saturates to 32 bits
    // before it is returned and before it goes into the feedback memory.
    function automatic int run_biquad(bit post_stage, int ch, int x);
        longint b0, a1, a2, acc;
        hist_t  h;
        int     y;
        if (post_stage) begin
            b0 = post_b0; a1 = post_a1; a2 = post_a2;
            h  = post_hist[ch];
        end else begin
            b0 = pre_b0; a1 = pre_a1; a2 = pre_a2;
            h  = pre_hist[ch];
        end
        acc = b0 * x - 2 * b0 * h.x1 + b0 * h.x2 - a1 * h.y1 - a2 * h.y2;
        y = sat32(round_shift(acc, COEF_SHIFT));
        h.x2 = h.x1;
        h.x1 = x;
        h.y2 = h.y1;
        h.y1 = y;
        if (post_stage) post_hist[ch] = h;
        else pre_hist[ch] = h;
        return y;
    endfunction

    // One channel: highpass, rectify, DC removal (the DC estimate follows afterwards),
    // clip to +-2.0, shape by h*(2-|h|), second highpass, then mix in at the strength.
    function automatic longint excite_channel(int ch, longint x);
        longint lim, h, d, mag;
        lim = longint'(1) <<< SW;
        h = run_biquad(1'b0, ch, int'(x));
        if (h < 0) h = -h;
        d = h - dc_level[ch];
        dc_level[ch] = sat32(dc_level[ch] + round_shift(d * DC_RATE, DC_SHIFT));
        d = clamp(d, -lim, lim);
        mag = (d < 0) ? -d : d;
        d = round_shift(d * (lim - mag), FRAC_W);
        return x + round_shift(longint'(run_biquad(1'b1, ch, sat32(d))) * longint'(strength),
                               STR_SHIFT);
    endfunction

    function automatic pair_t excite_pair(logic signed [SW-1:0] l, logic signed [SW-1:0] r,
                                          logic last);
        pair_t  p;
        longint y;
        y = clamp(excite_channel(0, longint'(l)), OUT_MIN, OUT_MAX);
        p.left = y[SW-1:0];
        // A channel beyond the configured count passes straight through.
        y = longint'(r);
        if (CH_CNT > 1) y = clamp(excite_channel(1, y), OUT_MIN, OUT_MAX);
        p.right = y[SW-1:0];
        p.last  = last;
        return p;
    endfunction

    // ------------------------------------------------------------------------------------
    // Result side: random back-pressure and scoring.
    // ------------------------------------------------------------------------------------
    pair_t       due [$];       // expected output pairs, oldest first
    int          mismatches = 0;
    bit          calm       = 1'b0;
    int          sent       = 0;
    int          rx_hold    = 0;
    logic [15:0] rx_tick    = '0;

    // Stalls come in bursts that start only while rx_tick bit 9 is set and calm is clear, so
    // there are long stretches without any back-pressure as well.
    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 1'b1;
        if (rx_hold != 0) begin
            rx_hold    <= rx_hold - 1;
            i_m_tready <= (rx_hold == 1);
        end else if (!calm && rx_tick[9] && $urandom_range(0, 5) == 0) begin
            rx_hold    <= $urandom_range(1, 12);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    task automatic note_mismatch(string what, longint want, longint got);
        mismatches++;
        if (mismatches <= SHOWN_ERRORS)
            $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
    endtask

    always @(posedge i_clk) begin : score_results
        pair_t want;
        pair_t got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.left  = o_m_tdata[SW-1:0];
            got.right = o_m_tdata[2*SW-1:SW];
            got.last  = o_m_tlast;
            if (due.size() == 0) begin
                note_mismatch("result with none pending, left", 0, got.left);
            end else begin
                want = due.pop_front();
                if (got.left !== want.left)
                    note_mismatch("left_out", want.left, got.left);
                if (got.right !== want.right)
                    note_mismatch("right_out", want.right, got.right);
                if (got.last !== want.last)
                    note_mismatch("block_end_out", want.last, got.last);
            end
        end
    end

    // ------------------------------------------------------------------------------------
    // Stimulus side.
    // ------------------------------------------------------------------------------------

    // Offers one sample pair and returns at the edge where it is taken. Valid is left high
    // so that a following pair can go out back to back; a random gap lowers it first.
    task automatic offer_pair(logic signed [SW-1:0] l, logic signed [SW-1:0] r, logic last);
        if (!calm && (sent % 96) < 64 && $urandom_range(0, 4) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= DATA_W'({r, l});
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        sent++;
    endtask

    // Stops offering and waits until every pending pair has come back, so that the unit is
    // idle. Each pair always yields a result, so no extra wait is needed.
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (due.size() != 0) @(posedge i_clk);
    endtask

    // Writes one register and mirrors it into the predictor once it is taken. Valid is
    // left high; the caller lowers it after the last write of a batch.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_PRE_B0:   pre_b0   = val;
            CFG_PRE_A1:   pre_a1   = val;
            CFG_PRE_A2:   pre_a2   = val;
            CFG_POST_B0:  post_b0  = val;
            CFG_POST_A1:  post_a1  = val;
            CFG_POST_A2:  post_a2  = val;
            CFG_STRENGTH: strength = val[STR_W-1:0];
            default: ;
        endcase
    endtask

    // Mostly full-range noise, some quiet signal, and now and then an extreme value.
    function automatic logic signed [SW-1:0] random_sample();
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 3))
                    0: return SAMPLE_MAX;
                    1: return SAMPLE_MIN;
                    2: return '0;
                    default: return '1;
                endcase
            end
            1, 2: return SW'(int'($urandom_range(0, 8191)) - 4096);
            default: return SW'($urandom);
        endcase
    endfunction

    plan_row_t plan [$];

    task automatic row_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        plan_row_t row;
        row = '0;
        row.kind    = ROW_REG;
        row.reg_idx = idx;
        row.reg_val = val;
        plan.push_back(row);
    endtask

    task automatic row_pair(logic signed [SW-1:0] l, logic signed [SW-1:0] r, logic last);
        plan_row_t row;
        row = '0;
        row.kind  = ROW_PAIR;
        row.left  = l;
        row.right = r;
        row.last  = last;
        plan.push_back(row);
    endtask

    task automatic row_known(logic signed [SW-1:0] l, logic signed [SW-1:0] r, logic last,
                             logic signed [SW-1:0] el, logic signed [SW-1:0] er);
        plan_row_t row;
        row = '0;
        row.kind      = ROW_PAIR;
        row.left      = l;
        row.right     = r;
        row.last      = last;
        row.known     = 1'b1;
        row.exp_left  = el;
        row.exp_right = er;
        plan.push_back(row);
    endtask

    initial begin : run
        int                    i, phase, n, recipe, pick;
        logic [CFG_DATA_W-1:0] coef [6];
        logic [CFG_DATA_W-1:0] strength_word;
        logic signed [SW-1:0]  l, r;
        logic                  last;
        pair_t                 want;

        // Out of reset every gain is zero, so the unit must pass samples through untouched.
        row_known(0, 0, 0, 0, 0);
        row_known(SAMPLE_MAX, SAMPLE_MIN, 1, SAMPLE_MAX, SAMPLE_MIN);
        row_known(SAMPLE_MIN, SAMPLE_MAX, 0, SAMPLE_MIN, SAMPLE_MAX);
        row_known(-1, 1, 1, -1, 1);
        row_known(SW'(24'h555555), SW'(24'hAAAAAA), 0, SW'(24'h555555), SW'(24'hAAAAAA));

        // A real treble setup: 8 kHz highpass in front, 4 kHz after the shaper, full strength.
        // Full-scale steps drive the mix into output saturation.
        row_reg(CFG_PRE_B0, COEF_W'(1950770));
        row_reg(CFG_PRE_A1, COEF_W'(-2601300));
        row_reg(CFG_PRE_A2, COEF_W'(1008310));
        row_reg(CFG_POST_B0, COEF_W'(2891100));
        row_reg(CFG_POST_A1, COEF_W'(-5367000));
        row_reg(CFG_POST_A2, COEF_W'(2003200));
        row_reg(CFG_STRENGTH, CFG_DATA_W'(STR_MAX));
        row_pair(SAMPLE_MAX, SAMPLE_MIN, 0);
        row_pair(SAMPLE_MIN, SAMPLE_MAX, 0);
        row_pair(SAMPLE_MAX, SAMPLE_MAX, 0);
        row_pair(0, 0, 1);
        row_pair(SAMPLE_MIN, SAMPLE_MIN, 0);
        row_pair(1000, -1000, 0);

        // A write to the unused index must leave every register alone.
        row_reg(CFG_UNUSED, '1);
        row_pair(SAMPLE_MAX, SAMPLE_MIN, 1);
        row_pair(-77, 4321, 0);

        // Coefficient extremes make both filters unstable, so their outputs hit the
        // 32-bit saturation within a few samples; the smallest nonzero strength follows.
        row_reg(CFG_PRE_B0, COEF_MAX);
        row_reg(CFG_PRE_A1, COEF_MIN);
        row_reg(CFG_PRE_A2, COEF_MAX);
        row_reg(CFG_POST_B0, COEF_MIN);
        row_reg(CFG_POST_A1, COEF_MIN);
        row_reg(CFG_POST_A2, COEF_MIN);
        row_reg(CFG_STRENGTH, CFG_DATA_W'(1));
        row_pair(SAMPLE_MAX, SAMPLE_MIN, 0);
        row_pair(SAMPLE_MIN, SAMPLE_MAX, 0);
        row_pair(SAMPLE_MAX, SAMPLE_MAX, 0);
        row_pair(0, 0, 0);
        row_pair(SAMPLE_MIN, SAMPLE_MIN, 1);
        row_pair(12345, -54321, 0);

        // With zero strength the air signal is dropped whatever the filters hold.
        row_reg(CFG_STRENGTH, '0);
        row_known(SAMPLE_MAX, SAMPLE_MIN, 0, SAMPLE_MAX, SAMPLE_MIN);
        row_known(0, -1, 1, 0, -1);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < plan.size(); i++) begin
            if (plan[i].kind == ROW_REG) begin
                drain();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
                if (i + 1 == plan.size() || plan[i + 1].kind != ROW_REG)
                    i_cfg_valid <= 1'b0;
            end else begin
                offer_pair(plan[i].left, plan[i].right, plan[i].last);
                want = excite_pair(plan[i].left, plan[i].right, plan[i].last);
                if (plan[i].known) begin
                    want.left  = plan[i].exp_left;
                    want.right = plan[i].exp_right;
                end
                due.push_back(want);
            end
        end

        // Random phases. The first three use all-max, all-min and fully random
        // coefficients; the rest pick among realistic highpass designs and those.
        for (phase = 0; phase < PHASES; phase++) begin
            recipe = (phase < 3) ? phase + 3 : $urandom_range(0, 5);
            case (recipe)
                0: begin   // 8 kHz in front, 4 kHz behind
                    coef[0] = COEF_W'(1950770); coef[1] = COEF_W'(-2601300);
                    coef[2] = COEF_W'(1008310); coef[3] = COEF_W'(2891100);
                    coef[4] = COEF_W'(-5367000); coef[5] = COEF_W'(2003200);
                end
                1: begin   // 4 kHz in front, 12 kHz behind
                    coef[0] = COEF_W'(2891100); coef[1] = COEF_W'(-5367000);
                    coef[2] = COEF_W'(2003200); coef[3] = COEF_W'(1228500);
                    coef[4] = '0;               coef[5] = COEF_W'(719700);
                end
                2: begin   // 12 kHz in front, 8 kHz behind
                    coef[0] = COEF_W'(1228500); coef[1] = '0;
                    coef[2] = COEF_W'(719700);  coef[3] = COEF_W'(1950770);
                    coef[4] = COEF_W'(-2601300); coef[5] = COEF_W'(1008310);
                end
                3: for (n = 0; n < 6; n++) coef[n] = COEF_MAX;
                4: for (n = 0; n < 6; n++) coef[n] = COEF_MIN;
                default: for (n = 0; n < 6; n++) coef[n] = CFG_DATA_W'($urandom);
            endcase
            // The bits above the strength field are random and must be ignored.
            strength_word = CFG_DATA_W'($urandom);
            pick = $urandom_range(0, 3);
            if (pick == 0) strength_word[STR_W-1:0] = STR_MAX;
            else if (pick == 1) strength_word[STR_W-1:0] = '0;

            drain();
            write_reg(CFG_PRE_B0, coef[0]);
            write_reg(CFG_PRE_A1, coef[1]);
            write_reg(CFG_PRE_A2, coef[2]);
            write_reg(CFG_POST_B0, coef[3]);
            write_reg(CFG_POST_A1, coef[4]);
            write_reg(CFG_POST_A2, coef[5]);
            write_reg(CFG_STRENGTH, strength_word);
            if ($urandom_range(0, 2) == 0) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
            i_cfg_valid <= 1'b0;

            // The final phase runs without gaps or stalls on either side.
            calm = (phase == PHASES - 1);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                l    = random_sample();
                r    = random_sample();
                last = ($urandom_range(0, 7) == 0);
                offer_pair(l, r, last);
                due.push_back(excite_pair(l, r, last));
            end
        end

        drain();
        // Give a stray extra result time to show up before the verdict.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && due.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
